### hw/rtl/tdfa_pkg.sv
// ----------------------------------------------------------------------------
// tdfa_pkg
// Shared types and constants for the table driven DFA matcher.
// ----------------------------------------------------------------------------
package tdfa_pkg;

    localparam int NUM_STATES_DEF  = 16;
    localparam int NUM_SYMBOLS_DEF = 128;

    // Request codes (req_type field)
    localparam logic [2:0] REQ_WRITE    = 3'd0;
    localparam logic [2:0] REQ_SET_FLAG = 3'd1;
    localparam logic [2:0] REQ_SYMBOL   = 3'd2;
    localparam logic [2:0] REQ_END      = 3'd3;
    localparam logic [2:0] REQ_READ     = 3'd4;

    // Result codes (result_kind field)
    localparam logic RES_VERDICT  = 1'b0;
    localparam logic RES_READBACK = 1'b1;

    typedef struct packed {
        logic [2:0] req_type;
        logic [3:0] state_index;
        logic [6:0] symbol;
        logic [3:0] dest_state;
        logic       dest_valid;
        logic       accept_value;
    } req_t;

    typedef struct packed {
        logic       result_kind;
        logic       accepted;
        logic [3:0] read_dest;
        logic       read_dest_valid;
        logic       read_accepting;
    } rsp_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_END
    } dfa_state_t;

endpackage

### hw/rtl/table_driven_dfa_matcher.sv
// ----------------------------------------------------------------------------
// table_driven_dfa_matcher
// DFA with a programmable transition table in synchronous RAM and one
// accept flag per state in flip-flops.
// ----------------------------------------------------------------------------
// Sequencing: a transition write, a flag set or an unknown request completes
// in IDLE. A symbol passes through READ: the table RAM is read with the current
// state and the symbol, and the state is updated from the registered read data,
// which forms the address of the next symbol's read. A read back passes through
// READ and an end of string through END, each waiting there for a free output
// register. After reset the table RAM is swept to "no transition", one entry a
// cycle, over all NUM_STATES * 2**ceil(log2(NUM_SYMBOLS)) entries (2048 with the
// defaults); no request is taken during the sweep.
module table_driven_dfa_matcher
    import tdfa_pkg::*;
#(
    parameter int NUM_STATES  = NUM_STATES_DEF,
    parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int ST_W   = $clog2(NUM_STATES);
    localparam int SYM_W  = $clog2(NUM_SYMBOLS);
    localparam int ADDR_W = ST_W + SYM_W;
    localparam int DEPTH  = NUM_STATES << SYM_W;
    localparam int ENT_W  = ST_W + 1;   // {valid, dest}

    dfa_state_t state_reg, state_next;

    logic [ADDR_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [ST_W-1:0]       cur_state_reg, cur_state_next;
    logic                  rejected_reg, rejected_next;
    logic [NUM_STATES-1:0] flags_reg, flags_next;
    req_t                  req_reg;
    rsp_t                  rsp_reg, rsp_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    logic [ENT_W-1:0]  mem [DEPTH];
    logic [ENT_W-1:0]  rd_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [ENT_W-1:0]  mem_wdata;

    logic              accept, slot_free, load_rsp, clr_done;
    logic              in_st_ok, in_sym_ok, q_st_ok, q_sym_ok;
    logic [ST_W-1:0]   flag_addr;
    logic              flag_rd;

    assign accept    = req_valid && req_ready;
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign clr_done  = (clr_cnt_reg == ADDR_W'(DEPTH - 1));

    assign in_st_ok  = 32'(req.state_index) < NUM_STATES;
    assign in_sym_ok = 32'(req.symbol) < NUM_SYMBOLS;
    assign q_st_ok   = 32'(req_reg.state_index) < NUM_STATES;
    assign q_sym_ok  = 32'(req_reg.symbol) < NUM_SYMBOLS;

    assign flag_addr = (state_reg == S_END) ? cur_state_reg : ST_W'(req_reg.state_index);
    assign flag_rd   = flags_reg[flag_addr];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept && (req.req_type == REQ_SYMBOL || req.req_type == REQ_READ))
                    state_next = S_READ;
                else if (accept && req.req_type == REQ_END)
                    state_next = S_END;
            end
            S_READ:
            begin
                if (req_reg.req_type != REQ_READ || slot_free)
                    state_next = S_IDLE;
            end
            S_END:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        req_ready      = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = (ADDR_W'(req.state_index) << SYM_W) | ADDR_W'(req.symbol);
        mem_raddr      = (ADDR_W'(cur_state_reg) << SYM_W) | ADDR_W'(req.symbol);
        mem_wdata      = '0;
        load_rsp       = 1'b0;
        rsp_next       = rsp_reg;
        clr_cnt_next   = clr_cnt_reg;
        cur_state_next = cur_state_reg;
        rejected_next  = rejected_reg;
        flags_next     = flags_reg;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (accept)
                begin
                    case (req.req_type)
                        REQ_WRITE:
                        begin
                            mem_we = in_st_ok && in_sym_ok;
                            if (req.dest_valid && 32'(req.dest_state) < NUM_STATES)
                                mem_wdata = {1'b1, ST_W'(req.dest_state)};
                        end
                        REQ_SET_FLAG:
                        begin
                            if (in_st_ok)
                                flags_next[ST_W'(req.state_index)] = req.accept_value;
                        end
                        REQ_SYMBOL:
                        begin
                            mem_re = 1'b1;
                        end
                        REQ_READ:
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = mem_waddr;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ:
            begin
                if (req_reg.req_type == REQ_READ)
                begin
                    if (slot_free)
                    begin
                        load_rsp                 = 1'b1;
                        rsp_next.result_kind     = RES_READBACK;
                        rsp_next.accepted        = 1'b0;
                        rsp_next.read_dest_valid = q_st_ok && q_sym_ok && rd_reg[ST_W];
                        rsp_next.read_dest       = rsp_next.read_dest_valid ?
                                                   4'(rd_reg[ST_W-1:0]) : 4'd0;
                        rsp_next.read_accepting  = q_st_ok && flag_rd;
                    end
                end
                else if (!rejected_reg)
                begin
                    // out of range symbol or empty entry rejects the string
                    if (q_sym_ok && rd_reg[ST_W])
                        cur_state_next = rd_reg[ST_W-1:0];
                    else
                        rejected_next = 1'b1;
                end
            end
            S_END:
            begin
                if (slot_free)
                begin
                    load_rsp                 = 1'b1;
                    rsp_next.result_kind     = RES_VERDICT;
                    rsp_next.accepted        = !rejected_reg && flag_rd;
                    rsp_next.read_dest       = 4'd0;
                    rsp_next.read_dest_valid = 1'b0;
                    rsp_next.read_accepting  = 1'b0;
                    cur_state_next           = '0;
                    rejected_next            = 1'b0;
                end
            end
            default: ;
        endcase

        if (load_rsp)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            cur_state_reg <= '0;
            rejected_reg  <= 1'b0;
            flags_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            cur_state_reg <= cur_state_next;
            rejected_reg  <= rejected_next;
            flags_reg     <= flags_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= req;
        if (load_rsp)
            rsp_reg <= rsp_next;
    end

    // transition table RAM, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_reg <= mem[mem_raddr];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // single-port table: never read and write in one cycle
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("table read and write in the same cycle");

    // a symbol blocks the next transaction until its state update is done
    a_sym_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.req_type == REQ_SYMBOL) |=> !req_ready)
        else $error("transaction taken during symbol update");

    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_state_reg) < NUM_STATES)
        else $error("current state out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_rsp |-> (!rsp_valid_reg || rsp_ready))
        else $error("pending result overwritten");

endmodule

### tb/table_driven_dfa_matcher_tb.sv
// ----------------------------------------------------------------------------
// table_driven_dfa_matcher_tb
// Self-checking bench for the DFA matcher. Transactions are queued up front,
// driven in random bursts and run through a local model of the automaton on
// acceptance. Each verdict and read back is checked against the model while
// the response side stalls on its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module table_driven_dfa_matcher_tb;
    import tdfa_pkg::*;

    localparam int NS        = NUM_STATES_DEF;
    localparam int NSYM      = NUM_SYMBOLS_DEF;
    localparam int RAND_REQS = 450;
    localparam int MAX_CYCLES = 200000;

    // Request codes the block ignores
    localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    table_driven_dfa_matcher uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Automaton mirror
    bit       trans_ok    [NS][NSYM];
    bit [3:0] trans_dst   [NS][NSYM];
    bit       accept_flag [NS];
    bit [3:0] cur_state;
    bit       str_dead;

    req_t dfa_requests[$];
    rsp_t due_responses[$];

    int errors = 0;
    int cycles = 0;
    int sent_cnt = 0;
    int taken_cnt = 0;
    int queued_items = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        $display("MISMATCH at cycle %0d: %s expected %0h got %0h",
                 cycles, what, exp_v, got_v);
        errors++;
    endtask

    // Apply one accepted transaction to the mirror, queue any response it owes
    task automatic dfa_apply(input req_t r);
        rsp_t o;
        int   st;
        int   sym;
        st  = int'(r.state_index);
        sym = int'(r.symbol);
        o   = '0;
        case (r.req_type)
            REQ_WRITE:
            begin
                if (st < NS && sym < NSYM)
                begin
                    trans_ok[st][sym]  = r.dest_valid && (int'(r.dest_state) < NS);
                    trans_dst[st][sym] = trans_ok[st][sym] ? r.dest_state : 4'd0;
                end
            end
            REQ_SET_FLAG:
            begin
                if (st < NS)
                    accept_flag[st] = r.accept_value;
            end
            REQ_SYMBOL:
            begin
                if (!str_dead)
                begin
                    if (sym < NSYM && trans_ok[cur_state][sym])
                        cur_state = trans_dst[cur_state][sym];
                    else
                        str_dead = 1'b1;
                end
            end
            REQ_END:
            begin
                o.result_kind = RES_VERDICT;
                o.accepted    = !str_dead && accept_flag[cur_state];
                due_responses.push_back(o);
                cur_state = '0;
                str_dead  = 1'b0;
            end
            REQ_READ:
            begin
                o.result_kind = RES_READBACK;
                if (st < NS && sym < NSYM && trans_ok[st][sym])
                begin
                    o.read_dest       = trans_dst[st][sym];
                    o.read_dest_valid = 1'b1;
                end
                if (st < NS)
                    o.read_accepting = accept_flag[st];
                due_responses.push_back(o);
            end
            default: ;
        endcase
    endtask

    // Stimulus builders; unused fields carry random junk
    function automatic req_t junk_req();
        req_t r;
        r.req_type     = 3'($urandom_range(0, 7));
        r.state_index  = 4'($urandom_range(0, 15));
        r.symbol       = 7'($urandom_range(0, 127));
        r.dest_state   = 4'($urandom_range(0, 15));
        r.dest_valid   = 1'($urandom_range(0, 1));
        r.accept_value = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic queue_req(input req_t r);
        dfa_requests.push_back(r);
        if (r.req_type <= REQ_READ)
            queued_items++;
    endtask

    task automatic put_write(input int st, input int sym, input int dst, input bit dv);
        req_t r;
        r = junk_req();
        r.req_type    = REQ_WRITE;
        r.state_index = 4'(st);
        r.symbol      = 7'(sym);
        r.dest_state  = 4'(dst);
        r.dest_valid  = dv;
        queue_req(r);
    endtask

    task automatic put_flag(input int st, input bit v);
        req_t r;
        r = junk_req();
        r.req_type     = REQ_SET_FLAG;
        r.state_index  = 4'(st);
        r.accept_value = v;
        queue_req(r);
    endtask

    task automatic put_symbol(input int sym);
        req_t r;
        r = junk_req();
        r.req_type = REQ_SYMBOL;
        r.symbol   = 7'(sym);
        queue_req(r);
    endtask

    task automatic put_end();
        req_t r;
        r = junk_req();
        r.req_type = REQ_END;
        queue_req(r);
    endtask

    task automatic put_read(input int st, input int sym);
        req_t r;
        r = junk_req();
        r.req_type    = REQ_READ;
        r.state_index = 4'(st);
        r.symbol      = 7'(sym);
        queue_req(r);
    endtask

    task automatic put_unused(input logic [2:0] code);
        req_t r;
        r = junk_req();
        r.req_type = code;
        queue_req(r);
    endtask

    // Request driver: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!(req_valid && sent_cnt != taken_cnt))
        begin
            if (gap_left != 0)
            begin
                req_valid <= 1'b0;
                gap_left--;
            end
            else if (dfa_requests.size() != 0)
            begin
                req       <= dfa_requests[0];
                req_valid <= 1'b1;
                sent_cnt++;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Response stall pattern: runs of ready and stall, mostly ready
    int rx_left = 0;

    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                rsp_ready <= 1'b1;
                rx_left = $urandom_range(1, 40);
            end
            else
            begin
                rsp_ready <= 1'b0;
                rx_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                       : $urandom_range(1, 4);
            end
        end
        else
        begin
            rx_left--;
        end
    end

    // Monitor and predictor
    always @(posedge clk)
    begin
        rsp_t want;
        cycles++;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (due_responses.size() == 0)
                begin
                    note_mismatch("response with none outstanding", 32'd0, 32'(rsp));
                end
                else
                begin
                    want = due_responses.pop_front();
                    if (rsp.result_kind !== want.result_kind)
                        note_mismatch("result_kind", 32'(want.result_kind),
                                      32'(rsp.result_kind));
                    if (rsp.accepted !== want.accepted)
                        note_mismatch("accepted", 32'(want.accepted), 32'(rsp.accepted));
                    if (rsp.read_dest !== want.read_dest)
                        note_mismatch("read_dest", 32'(want.read_dest), 32'(rsp.read_dest));
                    if (rsp.read_dest_valid !== want.read_dest_valid)
                        note_mismatch("read_dest_valid", 32'(want.read_dest_valid),
                                      32'(rsp.read_dest_valid));
                    if (rsp.read_accepting !== want.read_accepting)
                        note_mismatch("read_accepting", 32'(want.read_accepting),
                                      32'(rsp.read_accepting));
                end
            end
            if (req_valid && req_ready)
            begin
                dfa_apply(req);
                dfa_requests.delete(0);
                taken_cnt++;
            end
        end
        if (cycles > MAX_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int alpha [4];
        int target;
        int str_len;

        // Directed: corners of the table, flags, rejection, mid-string writes
        put_read(0, 0);                 // untouched entry reads back empty
        put_write(0, 0, 15, 1'b1);
        put_write(15, 127, 0, 1'b1);
        put_flag(15, 1'b1);
        put_flag(0, 1'b1);
        put_read(0, 0);
        put_read(15, 127);
        put_symbol(0);
        put_end();                      // ends in 15: accept
        put_symbol(0);
        put_symbol(127);
        put_end();                      // back to 0: accept
        put_end();                      // empty string
        put_symbol(5);                  // no transition: rejects
        put_symbol(0);                  // ignored after rejection
        put_end();
        put_symbol(0);
        put_write(15, 3, 7, 1'b1);      // write lands mid-string
        put_symbol(3);
        put_end();
        put_write(0, 0, 9, 1'b0);       // clear an entry
        put_read(0, 0);
        put_unused(REQ_UNUSED_LO);
        put_unused(3'(REQ_UNUSED_LO + 1));
        put_unused(REQ_UNUSED_HI);
        put_flag(0, 1'b0);
        put_end();

        // Random: small alphabets so strings walk deep through the table
        target = queued_items + RAND_REQS;
        while (queued_items < target)
        begin
            if ($urandom_range(0, 3) == 0 || queued_items < 40)
            begin
                foreach (alpha[i])
                    alpha[i] = $urandom_range(0, 127);
                if ($urandom_range(0, 3) == 0)
                    alpha[0] = 0;
                if ($urandom_range(0, 3) == 0)
                    alpha[3] = 127;
            end
            repeat ($urandom_range(4, 14))
                put_write($urandom_range(0, 15), alpha[$urandom_range(0, 3)],
                          $urandom_range(0, 15), $urandom_range(0, 9) != 0);
            repeat ($urandom_range(1, 4))
                put_flag($urandom_range(0, 15), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(2, 6))
            begin
                str_len = $urandom_range(0, 9);
                repeat (str_len)
                begin
                    case ($urandom_range(0, 19))
                        0: put_write($urandom_range(0, 15), alpha[$urandom_range(0, 3)],
                                     $urandom_range(0, 15), 1'($urandom_range(0, 1)));
                        1: put_read($urandom_range(0, 15), alpha[$urandom_range(0, 3)]);
                        2: put_unused(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)));
                        3: put_symbol($urandom_range(0, 127));
                        default: put_symbol(alpha[$urandom_range(0, 3)]);
                    endcase
                end
                put_end();
            end
            if ($urandom_range(0, 1) == 0)
                put_read($urandom_range(0, 15), ($urandom_range(0, 3) == 0)
                         ? $urandom_range(0, 127) : alpha[$urandom_range(0, 3)]);
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (dfa_requests.size() != 0 || due_responses.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
